@@ sv/wss_pkg.sv @@
`timescale 1ns / 1ps

package wss_pkg;

    // Line and store limits
    localparam int MAX_LINE     = 128;
    localparam int MAX_WORD_LEN = 16;
    localparam int MAX_WORDS    = 64;

    // Field widths
    localparam int CHAR_W = 8;
    localparam int LEN_W  = 5;
    localparam int HALF_W = 64;
    localparam int WORD_W = 2 * HALF_W;
    localparam int STAT_W = 2;
    localparam int NBYTES = WORD_W / CHAR_W;
    localparam int ENT_W  = WORD_W + LEN_W;

    // Store index, word count and line length widths
    localparam int AW     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CW     = $clog2(MAX_WORDS + 1);
    localparam int LINE_W = $clog2(MAX_LINE + 1);

    // Delimiter characters
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_BANG  = 8'h21;
    localparam logic [CHAR_W-1:0] CH_QUEST = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_OVF   = 2'd2
    } t_status;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic pos_clr;
        logic pos_inc;
        logic k_load;
        logic k_dec;
        logic rd_k;
        logic wr_en;
        logic wr_shift;
        logic cur_clr;
        logic ovf_set;
        logic cnt_inc;
        logic out_ld;
        logic out_status;
        logic line_clr;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic need_finish;
        logic active;
        logic pos_at_cnt;
        logic hit_eq;
        logic hit_lt;
        logic full;
        logic k_at_pos;
        logic line_end;
        logic no_result_words;
        logic out_last;
    } t_sts;

    function automatic logic is_delim(input logic [CHAR_W-1:0] c);
        logic d;
        case (c) inside
            CH_COMMA, CH_SEMI, CH_COLON, CH_DASH,
            CH_DOT, CH_BANG, CH_QUEST, CH_SPACE: d = 1'b1;
            default: d = 1'b0;
        endcase
        return d;
    endfunction

    // Put the first character in the most significant byte
    function automatic logic [WORD_W-1:0] rev_bytes(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] r;
        for (int i = 0; i < NBYTES; i++) begin
            r[(NBYTES-1-i)*CHAR_W +: CHAR_W] = w[i*CHAR_W +: CHAR_W];
        end
        return r;
    endfunction

endpackage

@@ sv/wss_if.sv @@
`timescale 1ns / 1ps

interface wss_in_if;
    logic                        valid;
    logic                        ready;
    logic [wss_pkg::CHAR_W-1:0] in_char;
    logic                        has_char;
    logic                        line_end;

    modport source (output valid, in_char, has_char, line_end, input ready);
    modport sink   (input valid, in_char, has_char, line_end, output ready);
endinterface

interface wss_out_if;
    logic                        valid;
    logic                        ready;
    logic [wss_pkg::HALF_W-1:0] word_low;
    logic [wss_pkg::HALF_W-1:0] word_high;
    logic [wss_pkg::LEN_W-1:0]  word_len;
    logic [wss_pkg::STAT_W-1:0] status;
    logic                        last_word;

    modport source (output valid, word_low, word_high, word_len, status, last_word,
                    input ready);
    modport sink   (input valid, word_low, word_high, word_len, status, last_word,
                    output ready);
endinterface

@@ sv/wss_ram.sv @@
`timescale 1ns / 1ps

module wss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry, read data registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/wss_datapath.sv @@
`timescale 1ns / 1ps

module wss_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [wss_pkg::CHAR_W-1:0]  i_in_char,
    input  logic                         i_has_char,
    input  logic                         i_line_end,
    input  wss_pkg::t_cmd                i_cmd,
    output wss_pkg::t_sts                o_sts,
    output logic [wss_pkg::HALF_W-1:0]  o_word_low,
    output logic [wss_pkg::HALF_W-1:0]  o_word_high,
    output logic [wss_pkg::LEN_W-1:0]   o_word_len,
    output logic [wss_pkg::STAT_W-1:0]  o_status,
    output logic                         o_last_word
);

    logic [wss_pkg::WORD_W-1:0] r_cur, n_cur;
    logic [wss_pkg::LEN_W-1:0]  r_cur_len, n_cur_len;
    logic [wss_pkg::LINE_W-1:0] r_line_len, n_line_len;
    logic                        r_ovf, n_ovf;
    logic                        r_end, n_end;
    logic [wss_pkg::CW-1:0]     r_count, n_count;
    logic [wss_pkg::CW-1:0]     r_pos, n_pos;
    logic [wss_pkg::CW-1:0]     r_k, n_k;

    logic [wss_pkg::HALF_W-1:0] r_o_low, r_o_high;
    logic [wss_pkg::LEN_W-1:0]  r_o_len;
    logic [wss_pkg::STAT_W-1:0] r_o_status;
    logic                        r_o_last;

    logic [wss_pkg::ENT_W-1:0]  rdata;
    logic [wss_pkg::ENT_W-1:0]  wdata;
    logic [wss_pkg::AW-1:0]     raddr, waddr;
    logic [wss_pkg::CW-1:0]     k_m1;
    logic [wss_pkg::ENT_W-1:0]  cur_key, ent_key;
    logic                        in_delim;
    logic                        char_live;

    assign in_delim  = wss_pkg::is_delim(i_in_char);
    assign char_live = i_has_char && !r_ovf;

    // Word store: {length, characters}
    assign k_m1  = r_k - wss_pkg::CW'(1);
    assign raddr = i_cmd.rd_k ? k_m1[wss_pkg::AW-1:0] : r_pos[wss_pkg::AW-1:0];
    assign waddr = i_cmd.wr_shift ? r_k[wss_pkg::AW-1:0] : r_pos[wss_pkg::AW-1:0];
    assign wdata = i_cmd.wr_shift ? rdata : {r_cur_len, r_cur};

    wss_ram #(
        .WIDTH (wss_pkg::ENT_W),
        .DEPTH (wss_pkg::MAX_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Byte order compare; zero padding plus length settles prefixes
    assign cur_key = {wss_pkg::rev_bytes(r_cur), r_cur_len};
    assign ent_key = {wss_pkg::rev_bytes(rdata[wss_pkg::WORD_W-1:0]),
                      rdata[wss_pkg::ENT_W-1:wss_pkg::WORD_W]};

    // Status to the controller
    always_comb begin
        o_sts.need_finish     = i_line_end ||
                                (char_live && (r_line_len < wss_pkg::LINE_W'(wss_pkg::MAX_LINE))
                                 && in_delim);
        o_sts.active          = (r_cur_len != '0) && !r_ovf;
        o_sts.pos_at_cnt      = (r_pos == r_count);
        o_sts.hit_eq          = (cur_key == ent_key);
        o_sts.hit_lt          = (cur_key < ent_key);
        o_sts.full            = (r_count >= wss_pkg::CW'(wss_pkg::MAX_WORDS));
        o_sts.k_at_pos        = (r_k == r_pos);
        o_sts.line_end        = r_end;
        o_sts.no_result_words = r_ovf || (r_count == '0);
        o_sts.out_last        = r_o_last;
    end

    // Next line state
    always_comb begin
        n_cur      = r_cur;
        n_cur_len  = r_cur_len;
        n_line_len = r_line_len;
        n_ovf      = r_ovf;
        n_end      = r_end;
        n_count    = r_count;
        n_pos      = r_pos;
        n_k        = r_k;

        // Take one character
        if (i_cmd.accept) begin
            n_end = i_line_end;
            if (char_live) begin
                if (r_line_len >= wss_pkg::LINE_W'(wss_pkg::MAX_LINE)) begin
                    n_ovf = 1'b1;
                end else begin
                    n_line_len = r_line_len + wss_pkg::LINE_W'(1);
                    if (!in_delim) begin
                        if (r_cur_len >= wss_pkg::LEN_W'(wss_pkg::MAX_WORD_LEN)) begin
                            n_ovf = 1'b1;
                        end else begin
                            for (int i = 0; i < wss_pkg::NBYTES; i++) begin
                                if (wss_pkg::LEN_W'(i) == r_cur_len) begin
                                    n_cur[i*wss_pkg::CHAR_W +: wss_pkg::CHAR_W] = i_in_char;
                                end
                            end
                            n_cur_len = r_cur_len + wss_pkg::LEN_W'(1);
                        end
                    end
                end
            end
        end

        if (i_cmd.ovf_set) begin
            n_ovf = 1'b1;
        end
        if (i_cmd.cur_clr) begin
            n_cur     = '0;
            n_cur_len = '0;
        end
        if (i_cmd.cnt_inc) begin
            n_count = r_count + wss_pkg::CW'(1);
        end
        if (i_cmd.pos_clr) begin
            n_pos = '0;
        end
        if (i_cmd.pos_inc) begin
            n_pos = r_pos + wss_pkg::CW'(1);
        end
        if (i_cmd.k_load) begin
            n_k = r_count;
        end
        if (i_cmd.k_dec) begin
            n_k = k_m1;
        end
        if (i_cmd.line_clr) begin
            n_cur      = '0;
            n_cur_len  = '0;
            n_line_len = '0;
            n_ovf      = 1'b0;
            n_end      = 1'b0;
            n_count    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur      <= '0;
            r_cur_len  <= '0;
            r_line_len <= '0;
            r_ovf      <= 1'b0;
            r_end      <= 1'b0;
            r_count    <= '0;
        end else begin
            r_cur      <= n_cur;
            r_cur_len  <= n_cur_len;
            r_line_len <= n_line_len;
            r_ovf      <= n_ovf;
            r_end      <= n_end;
            r_count    <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_k   <= n_k;
    end

    // Load the output register from the store or with a status result
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_o_low    <= rdata[wss_pkg::HALF_W-1:0];
            r_o_high   <= rdata[wss_pkg::WORD_W-1:wss_pkg::HALF_W];
            r_o_len    <= rdata[wss_pkg::ENT_W-1:wss_pkg::WORD_W];
            r_o_status <= wss_pkg::ST_OK;
            r_o_last   <= ((r_pos + wss_pkg::CW'(1)) == r_count);
        end else if (i_cmd.out_status) begin
            r_o_low    <= '0;
            r_o_high   <= '0;
            r_o_len    <= '0;
            r_o_status <= r_ovf ? wss_pkg::ST_OVF : wss_pkg::ST_EMPTY;
            r_o_last   <= 1'b1;
        end
    end

    assign o_word_low  = r_o_low;
    assign o_word_high = r_o_high;
    assign o_word_len  = r_o_len;
    assign o_status    = r_o_status;
    assign o_last_word = r_o_last;

endmodule

@@ sv/wss_ctrl.sv @@
`timescale 1ns / 1ps

module wss_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_ready,
    input  wss_pkg::t_sts  i_sts,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output wss_pkg::t_cmd  o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_FIN_CHK  = 13'b0000000000010,
        S_SCAN_RD  = 13'b0000000000100,
        S_SCAN_CMP = 13'b0000000001000,
        S_INS_CHK  = 13'b0000000010000,
        S_SHIFT_RD = 13'b0000000100000,
        S_SHIFT_WR = 13'b0000001000000,
        S_INSERT   = 13'b0000010000000,
        S_WDONE    = 13'b0000100000000,
        S_EMIT     = 13'b0001000000000,
        S_OUT_RD   = 13'b0010000000000,
        S_OUT_LD   = 13'b0100000000000,
        S_OUT_HOLD = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT_HOLD);

    // Sequence word insertion and result readout
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_sts.need_finish) begin
                    n_state = S_FIN_CHK;
                end
            end
            S_FIN_CHK: begin
                if (i_sts.active) begin
                    o_cmd.pos_clr = 1'b1;
                    n_state       = S_SCAN_RD;
                end else begin
                    n_state = S_WDONE;
                end
            end
            S_SCAN_RD: begin
                n_state = i_sts.pos_at_cnt ? S_INS_CHK : S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (i_sts.hit_eq) begin
                    n_state = S_WDONE;
                end else if (i_sts.hit_lt) begin
                    n_state = S_INS_CHK;
                end else begin
                    o_cmd.pos_inc = 1'b1;
                    n_state       = S_SCAN_RD;
                end
            end
            S_INS_CHK: begin
                if (i_sts.full) begin
                    o_cmd.ovf_set = 1'b1;
                    n_state       = S_WDONE;
                end else begin
                    o_cmd.k_load = 1'b1;
                    n_state      = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: begin
                if (i_sts.k_at_pos) begin
                    n_state = S_INSERT;
                end else begin
                    o_cmd.rd_k = 1'b1;
                    n_state    = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_shift = 1'b1;
                o_cmd.k_dec    = 1'b1;
                n_state        = S_SHIFT_RD;
            end
            S_INSERT: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                n_state       = S_WDONE;
            end
            S_WDONE: begin
                o_cmd.cur_clr = 1'b1;
                n_state       = i_sts.line_end ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (i_sts.no_result_words) begin
                    o_cmd.out_status = 1'b1;
                    n_state          = S_OUT_HOLD;
                end else begin
                    o_cmd.pos_clr = 1'b1;
                    n_state       = S_OUT_RD;
                end
            end
            S_OUT_RD: begin
                n_state = S_OUT_LD;
            end
            S_OUT_LD: begin
                o_cmd.out_ld = 1'b1;
                n_state      = S_OUT_HOLD;
            end
            S_OUT_HOLD: begin
                if (i_out_ready) begin
                    if (i_sts.out_last) begin
                        o_cmd.line_clr = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        o_cmd.pos_inc = 1'b1;
                        n_state       = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ sv/word_split_sort_unique.sv @@
`timescale 1ns / 1ps

// Splits a text line, taken one character per transfer, into words at the
// delimiters , ; : - . ! ? and space, and keeps the distinct words in a
// sorted store (ascending byte order, a proper prefix first). On the item
// marked line_end it sends every stored word in order, the last one flagged,
// or one status result when the line had no words or overflowed. A word end
// searches the store one entry at a time; a new word then shifts the larger
// entries up one place, each by a read and then a write of the store, and is
// written in the place so freed. Each word result is read from the store,
// loaded into the output register and held until the sink takes it; no new
// character is taken until the last result of the line has been transferred.
module word_split_sort_unique (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wss_in_if.sink     i_in,
    wss_out_if.source  o_out
);

    wss_pkg::t_cmd cmd;
    wss_pkg::t_sts sts;

    wss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    wss_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_char   (i_in.in_char),
        .i_has_char  (i_in.has_char),
        .i_line_end  (i_in.line_end),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_word_low  (o_out.word_low),
        .o_word_high (o_out.word_high),
        .o_word_len  (o_out.word_len),
        .o_status    (o_out.status),
        .o_last_word (o_out.last_word)
    );

`ifndef ASSERT_OFF
    // No character is taken while a result is offered
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input ready while a result is pending");

    // A status result is alone, last and empty
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status != wss_pkg::ST_OK))
        |-> (o_out.last_word && (o_out.word_len == '0)))
        else $error("status result not final or not empty");

    // A word result carries a real word
    a_word_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == wss_pkg::ST_OK))
        |-> ((o_out.word_len != '0)
             && (o_out.word_len <= wss_pkg::LEN_W'(wss_pkg::MAX_WORD_LEN))))
        else $error("word result with bad length");
`endif

endmodule
